FILE: src/tri3a_pkg.sv
`timescale 1ns / 1ps

package tri3a_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ANCHOR_A_X = 3'd0,
    REG_ANCHOR_A_Y = 3'd1,
    REG_ANCHOR_B_X = 3'd2,
    REG_ANCHOR_B_Y = 3'd3,
    REG_ANCHOR_C_X = 3'd4,
    REG_ANCHOR_C_Y = 3'd5
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_WIDTH = 3;

  // Control bits that travel beside each divider stage.
  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
  } div_ctl_t;

endpackage

FILE: src/tri3a_div.sv
`timescale 1ns / 1ps

module tri3a_div #(
  parameter int unsigned QW = 16,
  parameter int unsigned NW = 53,
  parameter int unsigned DW = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_neg,
  input  logic [NW-1:0]        in_num,
  input  logic [DW-1:0]        in_den,
  output logic                 out_valid,
  output logic signed [QW-1:0] out_quot,
  output logic                 out_clip
);
  import tri3a_pkg::*;

  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MAG = {1'b1, {(QW-1){1'b0}}};

  // Overflow check stage: a quotient of 2^QW or more always saturates.
  div_ctl_t          ctl_r [QW+1];
  logic [NW-1:0]     rem_r [QW+1];
  logic [DW-1:0]     den_r [QW+1];
  logic [QW-1:0]     quo_r [QW+1];
  logic              out_valid_r;
  logic signed [QW-1:0] out_quot_r;
  logic              out_clip_r;
  logic signed [QW-1:0] quot_nxt;
  logic              clip_nxt;
  div_ctl_t          ctl_last;
  logic [QW-1:0]     quo_last;

  // Stage 0 checks for overflow; each later stage settles one quotient bit,
  // most significant first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        ctl_r[k].valid <= 1'b0;
      end
    end else begin
      ctl_r[0].valid <= in_valid;
      for (int k = 0; k < QW; k++) begin
        ctl_r[k+1].valid <= ctl_r[k].valid;
      end
    end
    ctl_r[0].neg <= in_neg;
    ctl_r[0].ovf <= (NW + 1)'(in_num) >= (NW + 1)'({in_den, {QW{1'b0}}});
    rem_r[0]     <= in_num;
    den_r[0]     <= in_den;
    quo_r[0]     <= '0;
    for (int k = 0; k < QW; k++) begin
      ctl_r[k+1].neg <= ctl_r[k].neg;
      ctl_r[k+1].ovf <= ctl_r[k].ovf;
      den_r[k+1]     <= den_r[k];
      if (rem_r[k] >= (NW'(den_r[k]) << (QW - 1 - k))) begin
        rem_r[k+1] <= rem_r[k] - (NW'(den_r[k]) << (QW - 1 - k));
        quo_r[k+1] <= quo_r[k] | (QW'(1) << (QW - 1 - k));
      end else begin
        rem_r[k+1] <= rem_r[k];
        quo_r[k+1] <= quo_r[k];
      end
    end
  end

  assign ctl_last = ctl_r[QW];
  assign quo_last = quo_r[QW];

  always_comb begin
    clip_nxt = 1'b0;
    if (ctl_last.neg) begin
      if (ctl_last.ovf || quo_last > NEG_MAG) begin
        clip_nxt = 1'b1;
        quot_nxt = $signed(NEG_MAG);
      end else begin
        quot_nxt = $signed(-quo_last);
      end
    end else begin
      if (ctl_last.ovf || quo_last > POS_MAX) begin
        clip_nxt = 1'b1;
        quot_nxt = $signed(POS_MAX);
      end else begin
        quot_nxt = $signed(quo_last);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_last.valid;
    end
    out_quot_r <= quot_nxt;
    out_clip_r <= clip_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_quot  = out_quot_r;
  assign out_clip  = out_clip_r;

endmodule

FILE: src/trilateration_three_anchor.sv
`timescale 1ns / 1ps
// Closed-form 2D trilateration from three anchors in Q8.8 fixed point.
// A beat passes through stages 0 to 4, the two dividers and the output register.
// Throughput: one beat per cycle; busy is never raised and the receiver cannot stall.
// Reset (synchronous, rst_n low) clears every valid bit and the anchor registers.
// The depth is set by the two restoring dividers, one quotient bit per stage.

module trilateration_three_anchor #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [COORD_WIDTH-1:0]              in_range_a,
  input  logic [COORD_WIDTH-1:0]              in_range_b,
  input  logic [COORD_WIDTH-1:0]              in_range_c,
  output logic                                out_valid,
  output logic signed [COORD_WIDTH-1:0]       out_pos_x,
  output logic signed [COORD_WIDTH-1:0]       out_pos_y,
  output logic                                out_singular,
  output logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic [tri3a_pkg::CFG_IDX_WIDTH-1:0] cfg_idx,
  input  logic [COORD_WIDTH-1:0]              cfg_wdata
);
  import tri3a_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DFW = W + 1;       // anchor differences
  localparam int unsigned SW  = 2 * W + 3;   // S1, S2 and the determinant
  localparam int unsigned MW  = SW + DFW;    // Cramer partial products
  localparam int unsigned NW  = MW + 1;      // Cramer numerators
  localparam int unsigned DW  = SW + 1;      // divisor, twice the determinant
  localparam int unsigned SGL = W + 2;       // divider latency

  // Anchor registers: the user must write them only while the pipeline is empty; the block does not enforce it.
  logic signed [W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ANCHOR_A_X: ax_r <= cfg_wdata;
        REG_ANCHOR_A_Y: ay_r <= cfg_wdata;
        REG_ANCHOR_B_X: bx_r <= cfg_wdata;
        REG_ANCHOR_B_Y: by_r <= cfg_wdata;
        REG_ANCHOR_C_X: cx_r <= cfg_wdata;
        REG_ANCHOR_C_Y: cy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The block never holds off a beat.
  assign busy = 1'b0;

  // Stage 0: capture the ranges.
  logic         v0_r;
  logic [W-1:0] ra_r, rb_r, rc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    ra_r <= in_range_a;
    rb_r <= in_range_b;
    rc_r <= in_range_c;
  end

  // Stage 1: squares of ranges and anchors, anchor differences.
  logic [2*W-1:0]        sqra, sqrb, sqrc;
  logic signed [2*W-1:0] sqax, sqay, sqbx, sqby, sqcx, sqcy;
  logic                  v1_r;
  logic [2*W-1:0]        sqra_r, sqrb_r, sqrc_r;
  logic signed [SW-1:0]  an1_r, an2_r;
  logic signed [DFW-1:0] dxab_r, dyab_r, dxbc_r, dybc_r;

  assign sqra = ra_r * ra_r;
  assign sqrb = rb_r * rb_r;
  assign sqrc = rc_r * rc_r;
  assign sqax = ax_r * ax_r;
  assign sqay = ay_r * ay_r;
  assign sqbx = bx_r * bx_r;
  assign sqby = by_r * by_r;
  assign sqcx = cx_r * cx_r;
  assign sqcy = cy_r * cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    sqra_r <= sqra;
    sqrb_r <= sqrb;
    sqrc_r <= sqrc;
    an1_r  <= SW'(sqbx) - SW'(sqax) + SW'(sqby) - SW'(sqay);
    an2_r  <= SW'(sqcx) - SW'(sqbx) + SW'(sqcy) - SW'(sqby);
    dxab_r <= DFW'(bx_r) - DFW'(ax_r);
    dyab_r <= DFW'(by_r) - DFW'(ay_r);
    dxbc_r <= DFW'(cx_r) - DFW'(bx_r);
    dybc_r <= DFW'(cy_r) - DFW'(by_r);
  end

  // Stage 2: right-hand sides S1, S2 and the two determinant products.
  logic                  v2_r;
  logic signed [SW-1:0]  s1_r, s2_r, pd1_r, pd2_r;
  logic signed [DFW-1:0] dxab2_r, dyab2_r, dxbc2_r, dybc2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    s1_r    <= an1_r + $signed({3'b000, sqra_r}) - $signed({3'b000, sqrb_r});
    s2_r    <= an2_r + $signed({3'b000, sqrb_r}) - $signed({3'b000, sqrc_r});
    pd1_r   <= dxab_r * dybc_r;
    pd2_r   <= dyab_r * dxbc_r;
    dxab2_r <= dxab_r;
    dyab2_r <= dyab_r;
    dxbc2_r <= dxbc_r;
    dybc2_r <= dybc_r;
  end

  // Stage 3: determinant and the four Cramer products.
  logic                 v3_r;
  logic signed [SW-1:0] det_r;
  logic signed [MW-1:0] m1_r, m2_r, m3_r, m4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    det_r <= pd1_r - pd2_r;
    m1_r  <= s1_r * dybc2_r;
    m2_r  <= s2_r * dyab2_r;
    m3_r  <= dxab2_r * s2_r;
    m4_r  <= dxbc2_r * s1_r;
  end

  // Stage 4: numerators and divisor split into sign and magnitude.
  logic signed [NW-1:0] nx, ny;
  logic signed [DW-1:0] den;
  logic                 v4_r, negx_r, negy_r, sing_r;
  logic [NW-1:0]        magx_r, magy_r;
  logic [DW-1:0]        magd_r;

  assign nx  = NW'(m1_r) - NW'(m2_r);
  assign ny  = NW'(m3_r) - NW'(m4_r);
  assign den = {det_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    negx_r <= nx[NW-1] ^ den[DW-1];
    negy_r <= ny[NW-1] ^ den[DW-1];
    sing_r <= det_r == '0;
    magx_r <= nx[NW-1] ? NW'(-nx) : NW'(nx);
    magy_r <= ny[NW-1] ? NW'(-ny) : NW'(ny);
    magd_r <= den[DW-1] ? DW'(-den) : DW'(den);
  end

  // Dividers: truncating quotient with saturation.
  logic                valx, valy, clipx, clipy;
  logic signed [W-1:0] qx, qy;

  tri3a_div #(.QW(W), .NW(NW), .DW(DW)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_neg    (negx_r),
    .in_num    (magx_r),
    .in_den    (magd_r),
    .out_valid (valx),
    .out_quot  (qx),
    .out_clip  (clipx)
  );

  tri3a_div #(.QW(W), .NW(NW), .DW(DW)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_neg    (negy_r),
    .in_num    (magy_r),
    .in_den    (magd_r),
    .out_valid (valy),
    .out_quot  (qy),
    .out_clip  (clipy)
  );

  // The singular flag rides alongside the dividers.
  logic sing_dly_r [SGL];

  always_ff @(posedge clk) begin
    sing_dly_r[0] <= sing_r;
    for (int i = 1; i < SGL; i++) begin
      sing_dly_r[i] <= sing_dly_r[i-1];
    end
  end

  // Output register: a singular beat forces zero coordinates and no clip.
  logic                out_valid_r, out_singular_r, out_clipped_r;
  logic signed [W-1:0] out_pos_x_r, out_pos_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valx && valy;
    end
    out_singular_r <= sing_dly_r[SGL-1];
    out_clipped_r  <= !sing_dly_r[SGL-1] && (clipx || clipy);
    out_pos_x_r    <= sing_dly_r[SGL-1] ? '0 : qx;
    out_pos_y_r    <= sing_dly_r[SGL-1] ? '0 : qy;
  end

  assign out_valid    = out_valid_r;
  assign out_pos_x    = out_pos_x_r;
  assign out_pos_y    = out_pos_y_r;
  assign out_singular = out_singular_r;
  assign out_clipped  = out_clipped_r;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the three-anchor trilateration block.
// The anchors are loaded through the configuration port while the pipeline is
// empty. Distance triples are then issued as beats on the start/busy
// handshake. Each accepted beat is run through a local fixed-point solver,
// and the predicted position is queued. Every out_valid strobe is compared
// with the oldest queued position.
module tb_top;
  import tri3a_pkg::*;

  localparam int unsigned W = 16;
  localparam int unsigned PIPE_DEPTH = W + 8;
  // Indexes past the end of the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;
  localparam logic signed [W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [W-1:0] COORD_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] pos_y;
    logic                singular;
    logic                clipped;
  } fix_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [W-1:0]             in_range_a = '0;
  logic [W-1:0]             in_range_b = '0;
  logic [W-1:0]             in_range_c = '0;
  logic                     out_valid;
  logic signed [W-1:0]      out_pos_x;
  logic signed [W-1:0]      out_pos_y;
  logic                     out_singular;
  logic                     out_clipped;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx = '0;
  logic [W-1:0]             cfg_wdata = '0;

  // The testbench's own copy of the anchor registers, indexed like the block's.
  logic signed [W-1:0] anchor_reg [6];

  fix_t pending_fixes [$];
  int   error_count = 0;
  // When set, the sender inserts random gaps between beats.
  bit   gaps_on = 1'b1;

  trilateration_three_anchor #(.COORD_WIDTH(W)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_range_a(in_range_a), .in_range_b(in_range_b), .in_range_c(in_range_c),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_singular(out_singular), .out_clipped(out_clipped),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Solves the two linear equations by Cramer's rule, at full width, so that
  // no intermediate term can overflow. SystemVerilog's signed division
  // already truncates towards zero, as the block is specified to do.
  function automatic fix_t solve_fix(logic [W-1:0] ra, logic [W-1:0] rb,
                                     logic [W-1:0] rc);
    logic signed [127:0] xa, ya, xb, yb, xc, yc, da, db, dc;
    logic signed [127:0] s1, s2, det, nx, ny, qx, qy;
    fix_t f;
    xa = anchor_reg[REG_ANCHOR_A_X]; ya = anchor_reg[REG_ANCHOR_A_Y];
    xb = anchor_reg[REG_ANCHOR_B_X]; yb = anchor_reg[REG_ANCHOR_B_Y];
    xc = anchor_reg[REG_ANCHOR_C_X]; yc = anchor_reg[REG_ANCHOR_C_Y];
    da = {112'd0, ra}; db = {112'd0, rb}; dc = {112'd0, rc};
    s1 = xb*xb - xa*xa + yb*yb - ya*ya + da*da - db*db;
    s2 = xc*xc - xb*xb + yc*yc - yb*yb + db*db - dc*dc;
    det = (xb - xa)*(yc - yb) - (yb - ya)*(xc - xb);
    f = '0;
    if (det == 0) begin
      f.singular = 1'b1;
      return f;
    end
    nx = s1*(yc - yb) - s2*(yb - ya);
    ny = (xb - xa)*s2 - (xc - xb)*s1;
    qx = nx / (2*det);
    qy = ny / (2*det);
    // Each coordinate saturates on its own; either one raises the clip flag.
    if (qx > COORD_MAX) begin
      f.pos_x = COORD_MAX; f.clipped = 1'b1;
    end else if (qx < COORD_MIN) begin
      f.pos_x = COORD_MIN; f.clipped = 1'b1;
    end else begin
      f.pos_x = qx[W-1:0];
    end
    if (qy > COORD_MAX) begin
      f.pos_y = COORD_MAX; f.clipped = 1'b1;
    end else if (qy < COORD_MIN) begin
      f.pos_y = COORD_MIN; f.clipped = 1'b1;
    end else begin
      f.pos_y = qy[W-1:0];
    end
    return f;
  endfunction

  // Result checker. Outputs are sampled at the rising edge, before that
  // edge's nonblocking updates land, so the strobed values are stable.
  always @(posedge clk) begin
    fix_t want;
    if (rst_n && out_valid) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_pos_x, out_pos_y);
        error_count++;
      end else begin
        want = pending_fixes.pop_front();
        if (out_pos_x !== want.pos_x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, out_pos_x);
          error_count++;
        end
        if (out_pos_y !== want.pos_y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, out_pos_y);
          error_count++;
        end
        if (out_singular !== want.singular) begin
          $display("%0t: singular expected %0b actual %0b", $time, want.singular,
                   out_singular);
          error_count++;
        end
        if (out_clipped !== want.clipped) begin
          $display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
                   out_clipped);
          error_count++;
        end
      end
    end
  end

  // Sends one distance triple as a beat. Start is left high afterwards, so
  // that back-to-back beats never lower and raise it in the same time step.
  // A random gap, when enabled, lowers start before the beat goes out.
  task automatic send_ranges(logic [W-1:0] ra, logic [W-1:0] rb, logic [W-1:0] rc);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start      <= 1'b1;
    in_range_a <= ra;
    in_range_b <= rb;
    in_range_c <= rc;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_fixes = {pending_fixes, solve_fix(ra, rb, rc)};
  endtask

  // Lowers start, waits for every queued result, and then allows the
  // pipeline depth to pass, so that the block is idle afterwards.
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Writes all six anchors back to back, and then drops the write enable.
  task automatic load_anchors(logic signed [W-1:0] ax, logic signed [W-1:0] ay,
                              logic signed [W-1:0] bx, logic signed [W-1:0] by,
                              logic signed [W-1:0] cx, logic signed [W-1:0] cy);
    logic signed [W-1:0] vals [6];
    vals = '{ax, ay, bx, by, cx, cy};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= i[CFG_IDX_WIDTH-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      anchor_reg[i] = vals[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Returns the rounded distance from (px, py) to anchor k, clamped to 16 bits.
  function automatic logic [W-1:0] range_to(int k, real px, real py);
    real dx, dy, d;
    dx = px - real'(anchor_reg[2*k]);
    dy = py - real'(anchor_reg[2*k+1]);
    d = $sqrt(dx*dx + dy*dy);
    if (d > 65535.0) return 16'hffff;
    return W'($rtoi(d + 0.5));
  endfunction

  // With the anchors at their reset value of zero, every beat is singular.
  task automatic test_reset_anchors();
    send_ranges(16'd0, 16'd0, 16'd0);
    send_ranges(16'hffff, 16'h1234, 16'h8000);
    drain_pipe();
  endtask

  // Covers an exact fix, range extremes, saturation in both directions,
  // collinear and coincident anchors, and anchors at the corners of the range.
  task automatic test_directed();
    load_anchors(16'sd0, 16'sd0, 16'sd2560, 16'sd0, 16'sd0, 16'sd2560);
    send_ranges(16'd1810, 16'd1810, 16'd1810);
    send_ranges(16'd0, 16'd0, 16'd0);
    send_ranges(16'hffff, 16'hffff, 16'hffff);
    send_ranges(16'hffff, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hffff, 16'd0);
    send_ranges(16'd0, 16'd0, 16'hffff);
    drain_pipe();
    // Anchors very close together make the quotient overflow.
    load_anchors(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1);
    send_ranges(16'hffff, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hffff, 16'hffff);
    send_ranges(16'd5, 16'd4, 16'd4);
    drain_pipe();
    // Collinear anchors, and then two anchors at the same place.
    load_anchors(16'sd0, 16'sd0, 16'sd100, 16'sd100, -16'sd300, -16'sd300);
    send_ranges(16'd100, 16'd200, 16'd300);
    drain_pipe();
    load_anchors(16'sd77, -16'sd5, 16'sd77, -16'sd5, 16'sd900, 16'sd33);
    send_ranges(16'd10, 16'd20, 16'd30);
    drain_pipe();
    load_anchors(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_ranges(16'd0, 16'd0, 16'd0);
    send_ranges(16'hffff, 16'hffff, 16'hffff);
    send_ranges(16'hffff, 16'd0, 16'h8000);
    send_ranges(16'd0, 16'hffff, 16'hffff);
    drain_pipe();
  endtask

  // Writes to the two unused indexes must leave the anchors untouched.
  task automatic test_spare_index();
    load_anchors(16'sd0, 16'sd0, 16'sd2560, 16'sd0, 16'sd0, 16'sd2560);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SPARE_6;
    cfg_wdata <= 16'h5a5a;
    @(posedge clk);
    cfg_idx   <= REG_SPARE_7;
    cfg_wdata <= 16'ha5a5;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_ranges(16'd1810, 16'd1810, 16'd1810);
    send_ranges(16'd900, 16'd2000, 16'd2400);
    drain_pipe();
  endtask

  // Random phases. Each one picks an anchor layout, and then mostly sends
  // ranges measured from a random point with a little noise. The rest are
  // raw random triples. Phase 3 pauses halfway through until the pipe is
  // empty, and the closing phases send without gaps.
  task automatic test_random();
    int span;
    int noise;
    real px, py;
    logic [W-1:0] r [3];
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 10) gaps_on = 1'b0;
      case (ph % 4)
        0: span = 32767;
        1: span = 4000;
        2: span = 300;
        default: span = 20;
      endcase
      if (ph == 5)
        load_anchors(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      else
        load_anchors(W'($urandom_range(0, 2*span) - span), W'($urandom_range(0, 2*span) - span),
                     W'($urandom_range(0, 2*span) - span), W'($urandom_range(0, 2*span) - span),
                     W'($urandom_range(0, 2*span) - span), W'($urandom_range(0, 2*span) - span));
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 4) != 0) begin
          px = real'(int'($urandom_range(0, 2*span)) - span);
          py = real'(int'($urandom_range(0, 2*span)) - span);
          for (int k = 0; k < 3; k++) begin
            r[k] = range_to(k, px, py);
            noise = $urandom_range(0, 6) - 3;
            if (r[k] > 3 && r[k] < 16'hfffc) r[k] = r[k] + W'(noise);
          end
        end else begin
          for (int k = 0; k < 3; k++) r[k] = W'($urandom);
        end
        send_ranges(r[0], r[1], r[2]);
        if (ph == 3 && n == 75) drain_pipe();
      end
      drain_pipe();
    end
  endtask

  initial begin
    foreach (anchor_reg[i]) anchor_reg[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_anchors();
    test_directed();
    test_spare_index();
    test_random();
    drain_pipe();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a block that stalls or never answers.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/tri3a_pkg.sv
src/tri3a_div.sv
src/trilateration_three_anchor.sv
test/tb_top.sv
